[hdl/query_value_percent_encoder_assert.svh]
// Assertion macros of the query value percent encoder RTL.
// No dependencies; included by qvpe_back, the only module that carries checks.
`ifndef QUERY_VALUE_PERCENT_ENCODER_ASSERT_SVH
`define QUERY_VALUE_PERCENT_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QVPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("qvpe same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define QVPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("qvpe next-cycle check failed");

`endif

[hdl/qvpe_pkg.sv]
// Types, character constants and helper functions of the query value percent encoder.
// No dependencies; used by every module of the block.
package qvpe_pkg;

	localparam int unsigned QueueDepthDefault = 4;

	localparam logic [7:0] CharQuery = 8'h3F; // '?'
	localparam logic [7:0] CharAmp   = 8'h26; // '&'
	localparam logic [7:0] CharSemi  = 8'h3B; // ';'
	localparam logic [7:0] CharEq    = 8'h3D; // '='
	localparam logic [7:0] CharPct   = 8'h25; // '%'
	localparam logic [7:0] CharZero  = 8'h30; // '0'
	localparam logic [7:0] HexAlphaBase = 8'h57; // 'a' - 10

	typedef struct packed {
		logic [7:0] in_char;
		logic       string_end;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_last;
		logic       string_last;
	} result_t;

	// Classified byte handed from front to back.
	typedef struct packed {
		logic [7:0] ch;
		logic       str_end;
		logic       escape;
	} cmd_t;

	function automatic logic is_clean(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
			8'h2D, 8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29};
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		return (nib <= 4'd9) ? (CharZero + {4'b0, nib}) : (HexAlphaBase + {4'b0, nib});
	endfunction

endpackage

[hdl/query_value_percent_encoder.sv]
// Top level of the query value percent encoder: front end, command queue, back end.
// Depends on qvpe_pkg, qvpe_front, qvpe_queue and qvpe_back.
//
// channel   handshake            payload
// item      push / full          qvpe_pkg::item_t   (in_char, string_end)
// result    pop / empty          qvpe_pkg::result_t (out_char, run_last, string_last)
//
// A plain or separator byte gives one output byte, an escaped byte three.
// Throughput is set by the back end's single output register: one result byte per cycle while results are popped.
// The front end takes a byte every cycle while the command queue (QueueDepth entries) has room.
// Reset clears the scan mode, queue pointers and count, beat counter and output valid; no clearing pass.
// A stalled result holds in the output register while the queue keeps absorbing input.
module query_value_percent_encoder #(
	parameter int unsigned QueueDepth = qvpe_pkg::QueueDepthDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  qvpe_pkg::item_t   item,
	input  logic              pop,
	output logic              empty,
	output qvpe_pkg::result_t result
);

	logic           cmd_wr;
	qvpe_pkg::cmd_t cmd_in;
	qvpe_pkg::cmd_t cmd_out;
	logic           cmd_valid;
	logic           cmd_pop;

	qvpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item       (item),
		.queue_full (full),
		.cmd_wr     (cmd_wr),
		.cmd        (cmd_in)
	);

	qvpe_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (cmd_wr),
		.wr_data   (cmd_in),
		.rd        (cmd_pop),
		.rd_data   (cmd_out),
		.full      (full),
		.not_empty (cmd_valid)
	);

	qvpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

[hdl/qvpe_front.sv]
// Front end: accepts bytes, tracks the URL scan mode and classifies each byte.
// Depends on qvpe_pkg.
module qvpe_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  qvpe_pkg::item_t  item,
	input  logic             queue_full,
	output logic             cmd_wr,
	output qvpe_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {
		MODE_PRE   = 2'd0,
		MODE_KEY   = 2'd1,
		MODE_VALUE = 2'd2
	} mode_t;

	mode_t mode_q;
	mode_t mode_next;
	logic  is_sep;
	logic  escape;

	assign cmd_wr = push && !queue_full;
	assign is_sep = (item.in_char == qvpe_pkg::CharAmp) || (item.in_char == qvpe_pkg::CharSemi);

	always_comb begin
		mode_next = mode_q;
		escape    = 1'b0;
		case (mode_q)
			MODE_VALUE: begin
				if (is_sep) begin
					mode_next = MODE_KEY;
				end else begin
					escape = !qvpe_pkg::is_clean(item.in_char);
				end
			end
			MODE_KEY: begin
				if (item.in_char == qvpe_pkg::CharEq) begin
					mode_next = MODE_VALUE;
				end
			end
			default: begin
				if (item.in_char == qvpe_pkg::CharQuery) begin
					mode_next = MODE_KEY;
				end
			end
		endcase
		if (item.string_end) begin
			mode_next = MODE_PRE;
		end
	end

	assign cmd.ch      = item.in_char;
	assign cmd.str_end = item.string_end;
	assign cmd.escape  = escape;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PRE;
		end else if (cmd_wr) begin
			mode_q <= mode_next;
		end
	end

endmodule

[hdl/qvpe_queue.sv]
// Short command queue between the front and back ends.
// Depends on qvpe_pkg.
module qvpe_queue #(
	parameter int unsigned Depth = qvpe_pkg::QueueDepthDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  qvpe_pkg::cmd_t wr_data,
	input  logic           rd,
	output qvpe_pkg::cmd_t rd_data,
	output logic           full,
	output logic           not_empty
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

	qvpe_pkg::cmd_t    mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_wr;
	logic              do_rd;

	assign full      = (count_q == DepthCnt);
	assign not_empty = (count_q != '0);
	assign do_wr     = wr && !full;
	assign do_rd     = rd && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/qvpe_back.sv]
// Back end: expands queued commands into one or three output bytes.
// Depends on qvpe_pkg and query_value_percent_encoder_assert.svh.
`include "query_value_percent_encoder_assert.svh"

module qvpe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  qvpe_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	input  logic              pop,
	output logic              empty,
	output qvpe_pkg::result_t result
);

	typedef enum logic [1:0] {
		BEAT_FIRST = 2'd0,
		BEAT_HIGH  = 2'd1,
		BEAT_LOW   = 2'd2
	} beat_t;

	beat_t              beat_q;
	logic               out_valid_q;
	qvpe_pkg::result_t  out_q;
	logic               advance;
	logic               load;
	logic               last_beat;
	logic [7:0]         byte_sel;

	assign advance = !out_valid_q || pop;
	assign load    = advance && cmd_valid;

	always_comb begin
		byte_sel  = cmd.ch;
		last_beat = 1'b1;
		if (cmd.escape) begin
			case (beat_q)
				BEAT_FIRST: begin
					byte_sel  = qvpe_pkg::CharPct;
					last_beat = 1'b0;
				end
				BEAT_HIGH: begin
					byte_sel  = qvpe_pkg::hex_digit(cmd.ch[7:4]);
					last_beat = 1'b0;
				end
				default: begin
					byte_sel  = qvpe_pkg::hex_digit(cmd.ch[3:0]);
					last_beat = 1'b1;
				end
			endcase
		end
	end

	assign cmd_pop = load && last_beat;
	assign empty   = !out_valid_q;
	assign result  = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_char    <= byte_sel;
			out_q.run_last    <= last_beat;
			out_q.string_last <= last_beat && cmd.str_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= BEAT_FIRST;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= cmd_valid;
			if (load) begin
				case (beat_q)
					BEAT_FIRST: beat_q <= last_beat ? BEAT_FIRST : BEAT_HIGH;
					BEAT_HIGH:  beat_q <= BEAT_LOW;
					default:    beat_q <= BEAT_FIRST;
				endcase
			end
		end
	end

	// a command stays queued until its last byte is loaded into the output register
	`QVPE_ASSERT_IMP(a_mid_escape_cmd_held, clk, arst_n, beat_q != BEAT_FIRST, cmd_valid && cmd.escape)
	// a non-final byte of an escape moves the beat counter on
	`QVPE_ASSERT_NXT(a_beat_advances, clk, arst_n, load && !last_beat, beat_q != BEAT_FIRST)
	// end-of-string marks only the final byte of a run
	`QVPE_ASSERT_IMP(a_string_last_on_run_last, clk, arst_n, !empty && result.string_last, result.run_last)

endmodule
